// ===== src/tssc_pkg.sv =====
// Shared constants, codes and the CRC-8 step for the scratchpad checker.
package tssc_pkg;

    localparam int unsigned MAX_SENSORS = 8;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int SENSOR_W = 3;
    localparam int COUNT_W  = 4;
    localparam int TEMP_W   = 13;
    localparam int STATUS_W = 2;
    localparam int RETRY_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Working width for the signed conversion result before saturation
    localparam int CONV_W = 18;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
    localparam logic [POS_W-1:0]  CRC_POS  = 4'd8;
    localparam logic [POS_W-1:0]  DONE_POS = 4'd9;
    localparam logic [POS_W-1:0]  HELD_DEPTH = 4'd4;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT = 2'd2;

    localparam logic [COUNT_W-1:0] SENSOR_COUNT_RESET = 4'd1;
    localparam logic [BYTE_W-1:0]  CAL_MARKER_RESET   = 8'd170;

    localparam logic [COUNT_W-1:0] SENSOR_LIMIT =
        (MAX_SENSORS < 8) ? COUNT_W'(MAX_SENSORS) : 4'd8;

    localparam logic signed [TEMP_W-1:0] FAIL_TEMP = 13'sd1990;
    localparam logic signed [CONV_W-1:0] TEMP_MAX  = 18'sd2175;
    localparam logic signed [CONV_W-1:0] TEMP_MIN  = -18'sd2176;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_GOOD      = 2'd0;
    localparam status_t STATUS_CRC_ERROR = 2'd1;
    localparam status_t STATUS_FAILED    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MARKER   = 1'd1;

    // One byte of the reflected Dallas/Maxim CRC-8, LSB first
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        logic              mix;
        c = crc;
        d = data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[BYTE_W-1:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[BYTE_W-1:1]};
        end
        return c;
    endfunction

endpackage

// ===== src/tssc_byte_if.sv =====
// Input channel: one scratchpad byte per transaction.
interface tssc_byte_if
    import tssc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== src/tssc_result_if.sv =====
// Output channel: one checked reading per transaction.
interface tssc_result_if
    import tssc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [SENSOR_W-1:0]      sensor_index;
    logic signed [TEMP_W-1:0] temperature;
    status_t                  status;

    modport source (output valid, output sensor_index, output temperature, output status,
                    input ready);
    modport sink   (input valid, input sensor_index, input temperature, input status,
                    output ready);
endinterface

// ===== src/temp_sensor_scratchpad_checker.sv =====
// Scratchpad checker: accepts one byte per cycle, one byte register then one result register.
// Takes one scratchpad byte per clock cycle, sustained, as long as the result side keeps up.
// Each byte is captured in an input register and processed from there, where the CRC-8 step,
// the byte counting and, on the ninth byte, the compare and the conversion to tenths of a
// degree all happen; the result lands in an output register. A result that is not taken only
// stalls input when the next pending byte would itself produce a result. A byte with
// frame_start restarts the frame; bytes after the CRC byte and before the next frame_start are
// dropped. Status 1 means the sensor is to be re-read; the third CRC failure in a row reports
// 1990 with status 2 and moves to the next sensor. Configuration must be written through
// cfg_write_en/cfg_index/cfg_data only while the block is idle; the block itself does not
// enforce this.
module temp_sensor_scratchpad_checker
    import tssc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    tssc_byte_if.sink            bytes,
    tssc_result_if.source        results
);

    // Configuration
    logic [COUNT_W-1:0] sensor_count_reg;
    logic [BYTE_W-1:0]  cal_marker_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    // Frame state
    logic [POS_W-1:0]    pos_reg,   pos_next;
    logic [BYTE_W-1:0]   crc_reg,   crc_next;
    logic [RETRY_W-1:0]  retry_reg, retry_next;
    logic [SENSOR_W-1:0] sensor_reg, sensor_next;
    logic [BYTE_W-1:0]   held_reg [HELD_DEPTH];

    // Result register
    logic                     out_valid_reg;
    logic [SENSOR_W-1:0]      out_sensor_reg;
    logic signed [TEMP_W-1:0] out_temp_reg, out_temp_next;
    status_t                  out_status_reg, out_status_next;

    logic [POS_W-1:0]  pos_eff;
    logic [BYTE_W-1:0] crc_eff;
    logic              produces;
    logic              advance;
    logic              accept;
    logic              hold_byte;

    logic [COUNT_W-1:0]  count_eff;
    logic [SENSOR_W-1:0] sensor_adv;

    logic [2*BYTE_W-1:0]      raw;
    logic                     neg;
    logic [2*BYTE_W:0]        mag;
    logic [2*BYTE_W+4:0]      prod;
    logic [CONV_W-1:0]        scaled;
    logic signed [CONV_W-1:0] val;
    logic signed [CONV_W-1:0] offset;
    logic signed [CONV_W-1:0] sum;
    logic signed [CONV_W-1:0] sat;

    assign pos_eff  = in_start_reg ? '0 : pos_reg;
    assign crc_eff  = in_start_reg ? '0 : crc_reg;
    assign produces = (pos_eff == CRC_POS);

    // Advance the pending byte unless it needs the result slot and the slot is blocked
    assign advance = in_valid_reg && (!produces || !out_valid_reg || results.ready);
    assign bytes.ready = !in_valid_reg || advance;
    assign accept = bytes.valid && bytes.ready;
    assign hold_byte = advance && (pos_eff < HELD_DEPTH);

    always_comb
    begin
        if (sensor_count_reg == '0)
        begin
            count_eff = 4'd1;
        end
        else if (sensor_count_reg > SENSOR_LIMIT)
        begin
            count_eff = SENSOR_LIMIT;
        end
        else
        begin
            count_eff = sensor_count_reg;
        end
        if ({1'b0, sensor_reg} + 4'd1 >= count_eff)
        begin
            sensor_adv = '0;
        end
        else
        begin
            sensor_adv = sensor_reg + 3'd1;
        end
    end

    // Convert the 1/16-degree reading to tenths, truncating toward zero; add offset and saturate
    always_comb
    begin
        raw    = {held_reg[1], held_reg[0]};
        neg    = raw[2*BYTE_W-1];
        mag    = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        prod   = 21'(mag) * 21'd10;
        scaled = CONV_W'(prod[2*BYTE_W+4:4]);
        val    = neg ? -$signed(scaled) : $signed(scaled);
        offset = $signed({{(CONV_W-BYTE_W){held_reg[3][BYTE_W-1]}}, held_reg[3]});
        sum    = (held_reg[2] == cal_marker_reg) ? (val + offset) : val;
        if (sum > TEMP_MAX)
        begin
            sat = TEMP_MAX;
        end
        else if (sum < TEMP_MIN)
        begin
            sat = TEMP_MIN;
        end
        else
        begin
            sat = sum;
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        retry_next      = retry_reg;
        sensor_next     = sensor_reg;
        out_temp_next   = '0;
        out_status_next = STATUS_GOOD;
        if (pos_eff < CRC_POS)
        begin
            crc_next = crc8_update(crc_eff, in_byte_reg);
            pos_next = pos_eff + 4'd1;
        end
        else if (produces)
        begin
            pos_next = DONE_POS;
            crc_next = crc_eff;
            if (crc_eff == in_byte_reg)
            begin
                retry_next      = '0;
                out_temp_next   = sat[TEMP_W-1:0];
                out_status_next = STATUS_GOOD;
                sensor_next     = sensor_adv;
            end
            else if (retry_reg + 2'd1 > RETRY_LIMIT)
            begin
                retry_next      = '0;
                out_temp_next   = FAIL_TEMP;
                out_status_next = STATUS_FAILED;
                sensor_next     = sensor_adv;
            end
            else
            begin
                retry_next      = retry_reg + 2'd1;
                out_status_next = STATUS_CRC_ERROR;
            end
        end
        else
        begin
            // Past the CRC byte: drop until the next frame start
            pos_next = pos_eff;
            crc_next = crc_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= SENSOR_COUNT_RESET;
            cal_marker_reg   <= CAL_MARKER_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_SENSOR_COUNT: sensor_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_CAL_MARKER:   cal_marker_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= '0;
            retry_reg     <= '0;
            sensor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (bytes.ready)
            begin
                in_valid_reg <= bytes.valid;
            end
            if (advance)
            begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                retry_reg  <= retry_next;
                sensor_reg <= sensor_next;
            end
            if (advance && produces)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= bytes.data_byte;
            in_start_reg <= bytes.frame_start;
        end
        if (hold_byte)
        begin
            held_reg[pos_eff[1:0]] <= in_byte_reg;
        end
        if (advance && produces)
        begin
            out_sensor_reg <= sensor_reg;
            out_temp_reg   <= out_temp_next;
            out_status_reg <= out_status_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.sensor_index = out_sensor_reg;
    assign results.temperature  = out_temp_reg;
    assign results.status       = out_status_reg;

endmodule

// ===== verif/tb_temp_sensor_scratchpad_checker.sv =====
// Self-checking testbench for the scratchpad checker: directed frames, then randomized polling.
module tb_temp_sensor_scratchpad_checker;
    import tssc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TENTHS_MAX   = 2175;
    localparam int TENTHS_MIN   = -2176;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_GAP      = 18;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SENSOR_W-1:0]      sensor;
        logic signed [TEMP_W-1:0] tenths;
        status_t                  status;
    } reading_t;

    // What to put on the byte lane: the byte as written, the CRC the block must see, or a bad CRC
    typedef enum logic [1:0] {
        KEEP_BYTE,
        GOOD_CRC,
        BAD_CRC
    } crc_pick_t;

    typedef struct packed {
        logic          fs;
        logic [7:0]    data;
        crc_pick_t     pick;
        logic          typed;
        reading_t      want;
    } script_row_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               rand_marker;
        logic [BYTE_W-1:0]  marker;
        int unsigned        bad_pct;
        int unsigned        target;
    } poll_setting_t;

    localparam reading_t NO_READING = '0;
    localparam reading_t HOT_LIMIT  = '{3'd0, 13'sd2175, STATUS_GOOD};
    localparam reading_t COLD_LIMIT = '{3'd0, -13'sd2176, STATUS_GOOD};
    localparam reading_t REREAD     = '{3'd0, 13'sd0, STATUS_CRC_ERROR};

    localparam int DIRECTED_LEN = 29;
    localparam script_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // hottest raw reading plus the largest positive offset
        '{1'b1, 8'hFF, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h7F, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'hAA, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h7F, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, GOOD_CRC,  1'b1, HOT_LIMIT},
        // stray byte after the CRC byte, then a frame cut short by a restart
        '{1'b0, 8'h55, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b1, 8'h12, KEEP_BYTE, 1'b0, NO_READING},
        // coldest raw reading plus the largest negative offset
        '{1'b1, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h80, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'hAA, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h80, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'hFF, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'hFF, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'hFF, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'hFF, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, GOOD_CRC,  1'b1, COLD_LIMIT},
        // corrupted CRC: re-read the same sensor
        '{1'b1, 8'h90, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h01, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, KEEP_BYTE, 1'b0, NO_READING},
        '{1'b0, 8'h00, BAD_CRC,   1'b1, REREAD}
    };

    localparam int SETTING_LEN = 5;
    localparam poll_setting_t POLL_SETTINGS [SETTING_LEN] = '{
        '{4'd8,  1'b1, 8'h00, 30, 110},
        '{4'd0,  1'b0, 8'h00, 40, 50},
        '{4'd15, 1'b0, 8'hFF, 70, 60},
        '{4'd3,  1'b1, 8'h00, 50, 60},
        '{4'd2,  1'b1, 8'h00, 60, 50}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    tssc_byte_if   byte_ch ();
    tssc_result_if reading_ch ();

    temp_sensor_scratchpad_checker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .bytes        (byte_ch.sink),
        .results      (reading_ch.source)
    );

    // Shadow of the checker's registers and frame state
    logic [COUNT_W-1:0]  sensor_count_q;
    logic [BYTE_W-1:0]   cal_marker_q;
    logic [POS_W-1:0]    frame_pos;
    logic [BYTE_W-1:0]   crc_run;
    logic [BYTE_W-1:0]   held_data [4];
    logic [RETRY_W-1:0]  fail_streak;
    logic [SENSOR_W-1:0] poll_sensor;

    reading_t    expected_readings [$];
    int unsigned mismatches;
    int unsigned consumed_bytes;
    int unsigned crc_bad_pct;
    bit          src_quiet;
    bit          sink_quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] crc_after(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] acc;
        acc = crc ^ data;
        repeat (8)
        begin
            acc = acc[0] ? ((acc >> 1) ^ 8'h8C) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic void reset_shadow();
        sensor_count_q = SENSOR_COUNT_RESET;
        cal_marker_q   = CAL_MARKER_RESET;
        frame_pos      = '0;
        crc_run        = '0;
        fail_streak    = '0;
        poll_sensor    = '0;
        for (int i = 0; i < 4; i++)
        begin
            held_data[i] = '0;
        end
    endfunction

    function automatic void next_sensor();
        int n;
        n = int'(sensor_count_q);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > int'(SENSOR_LIMIT))
        begin
            n = int'(SENSOR_LIMIT);
        end
        poll_sensor = (int'(poll_sensor) + 1 >= n) ? '0 : poll_sensor + 1'b1;
    endfunction

    function automatic int reading_in_tenths();
        logic signed [15:0] raw;
        int                 sixteenths;
        int                 tenths;
        raw        = {held_data[1], held_data[0]};
        sixteenths = int'(raw);
        tenths     = ((sixteenths < 0) ? -sixteenths : sixteenths) * 10 / 16;
        if (sixteenths < 0)
        begin
            tenths = -tenths;
        end
        if (held_data[2] == cal_marker_q)
        begin
            tenths += int'($signed(held_data[3]));
        end
        if (tenths > TENTHS_MAX)
        begin
            tenths = TENTHS_MAX;
        end
        if (tenths < TENTHS_MIN)
        begin
            tenths = TENTHS_MIN;
        end
        return tenths;
    endfunction

    // Advance the shadow by one byte; returns 1 when the byte closes a frame
    function automatic bit predict_byte(input logic [BYTE_W-1:0] data, input logic fs,
                                        output reading_t r);
        r = NO_READING;
        if (fs)
        begin
            frame_pos = '0;
            crc_run   = '0;
        end
        if (frame_pos < CRC_POS)
        begin
            if (frame_pos < HELD_DEPTH)
            begin
                held_data[frame_pos[1:0]] = data;
            end
            crc_run   = crc_after(crc_run, data);
            frame_pos = frame_pos + 1'b1;
            return 1'b0;
        end
        if (frame_pos != CRC_POS)
        begin
            return 1'b0;
        end
        frame_pos = DONE_POS;
        r.sensor  = poll_sensor;
        if (crc_run == data)
        begin
            fail_streak = '0;
            r.tenths    = TEMP_W'(reading_in_tenths());
            r.status    = STATUS_GOOD;
            next_sensor();
        end
        else
        begin
            fail_streak = fail_streak + 1'b1;
            if (fail_streak > RETRY_LIMIT)
            begin
                fail_streak = '0;
                r.tenths    = FAIL_TEMP;
                r.status    = STATUS_FAILED;
                next_sensor();
            end
            else
            begin
                r.tenths = '0;
                r.status = STATUS_CRC_ERROR;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic fs,
                             input crc_pick_t pick, output bit got, output reading_t r);
        int gap;
        if ($urandom_range(0, 19) == 0)
        begin
            src_quiet = !src_quiet;
        end
        gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        case (pick)
            GOOD_CRC: value = crc_run;
            BAD_CRC:  value = crc_run ^ BYTE_W'($urandom_range(1, 255));
            default:  value = value;
        endcase
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= value;
        byte_ch.frame_start <= fs;
        do @(posedge clk); while (byte_ch.ready !== 1'b1);
        if (fs || frame_pos <= CRC_POS)
        begin
            consumed_bytes++;
        end
        got = predict_byte(value, fs, r);
    endtask

    task automatic feed(input logic [BYTE_W-1:0] value, input logic fs, input crc_pick_t pick);
        bit       got;
        reading_t r;
        send_byte(value, fs, pick, got, r);
        if (got)
        begin
            expected_readings.push_back(r);
        end
    endtask

    task automatic send_random_stretch();
        logic [15:0]       raw;
        logic [BYTE_W-1:0] frame [8];
        int                choice;
        int                near;
        int                n;
        choice = $urandom_range(0, 99);
        if (choice < 8)
        begin
            // stray bytes, normally dropped after a finished frame
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
            begin
                feed(BYTE_W'($urandom), 1'b0, KEEP_BYTE);
            end
        end
        else if (choice < 16)
        begin
            // frame cut short; the next frame start drops it
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
            begin
                feed(BYTE_W'($urandom), k == 0, KEEP_BYTE);
            end
        end
        else
        begin
            case ($urandom_range(0, 7))
                0: raw = 16'h7FFF;
                1: raw = 16'h8000;
                2: raw = 16'h0000;
                3: raw = 16'hFFFF;
                4:
                begin
                    // around the saturation points
                    near = 3180 + int'($urandom_range(0, 600));
                    raw  = $urandom_range(0, 1) ? 16'(near) : 16'(-near);
                end
                default: raw = 16'($urandom);
            endcase
            frame[0] = raw[7:0];
            frame[1] = raw[15:8];
            frame[2] = $urandom_range(0, 1) ? cal_marker_q : BYTE_W'($urandom);
            for (int k = 3; k < 8; k++)
            begin
                frame[k] = BYTE_W'($urandom);
            end
            // a few frames come without a frame start
            for (int k = 0; k < 8; k++)
            begin
                feed(frame[k], (k == 0) && (choice >= 20), KEEP_BYTE);
            end
            feed(8'h00, 1'b0,
                 ($urandom_range(0, 99) < crc_bad_pct) ? BAD_CRC : GOOD_CRC);
        end
    endtask

    task automatic settle_block();
        byte_ch.valid <= 1'b0;
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [BYTE_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_SENSOR_COUNT)
        begin
            sensor_count_q = value[COUNT_W-1:0];
        end
        else
        begin
            cal_marker_q = value;
        end
    endtask

    initial
    begin : reading_sink
        int       gap;
        reading_t want;
        reading_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                sink_quiet = !sink_quiet;
            end
            gap = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                reading_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            reading_ch.ready <= 1'b1;
            do @(posedge clk); while (reading_ch.valid !== 1'b1);
            if (expected_readings.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $display("unexpected reading: sensor %0d temp %0d status %0d",
                             reading_ch.sensor_index, reading_ch.temperature,
                             reading_ch.status);
                end
                mismatches++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (reading_ch.sensor_index !== want.sensor ||
                    reading_ch.temperature !== want.tenths ||
                    reading_ch.status !== want.status)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display({"reading mismatch: sensor %0d temp %0d status %0d, ",
                                  "expected %0d %0d %0d"},
                                 reading_ch.sensor_index, reading_ch.temperature,
                                 reading_ch.status, want.sensor, want.tenths, want.status);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : byte_source
        bit          got;
        reading_t    r;
        int unsigned goal;
        rst_n               <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_index           <= CFG_SENSOR_COUNT;
        cfg_data            <= '0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.frame_start <= 1'b0;
        mismatches     = 0;
        consumed_bytes = 0;
        crc_bad_pct    = 30;
        src_quiet      = 1'b0;
        sink_quiet     = 1'b0;
        reset_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset configuration
        for (int i = 0; i < DIRECTED_LEN; i++)
        begin
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].fs, DIRECTED_ROWS[i].pick, got, r);
            if (DIRECTED_ROWS[i].typed)
            begin
                expected_readings.push_back(DIRECTED_ROWS[i].want);
            end
            else if (got)
            begin
                expected_readings.push_back(r);
            end
        end

        goal = consumed_bytes + 60;
        while (consumed_bytes < goal)
        begin
            send_random_stretch();
        end

        for (int p = 0; p < SETTING_LEN; p++)
        begin
            settle_block();
            // upper nibble is don't-care for the count register
            write_register(CFG_SENSOR_COUNT,
                           {4'($urandom), POLL_SETTINGS[p].count});
            write_register(CFG_CAL_MARKER, POLL_SETTINGS[p].rand_marker ?
                           BYTE_W'($urandom) : POLL_SETTINGS[p].marker);
            crc_bad_pct = POLL_SETTINGS[p].bad_pct;
            goal = consumed_bytes + POLL_SETTINGS[p].target;
            while (consumed_bytes < goal)
            begin
                send_random_stretch();
            end
        end

        settle_block();
        if (mismatches == 0 && expected_readings.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/tssc_pkg.sv
src/tssc_byte_if.sv
src/tssc_result_if.sv
src/temp_sensor_scratchpad_checker.sv
verif/tb_temp_sensor_scratchpad_checker.sv
